// ----- src/priority_alarm_latch_with_mute_defines.svh -----
// Assertion macros for the alarm latch block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef PRIORITY_ALARM_LATCH_WITH_MUTE_DEFINES_SVH
`define PRIORITY_ALARM_LATCH_WITH_MUTE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define PLAM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define PLAM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/plam_pkg.sv -----
// Shared types, codes and the level lookup for the alarm latch block.
// No dependencies.
`default_nettype none

package plam_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        FUNC_RAISE = 2'd0,
        FUNC_ACK   = 2'd1,
        FUNC_MUTE  = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    // Priority levels
    localparam logic [1:0] LVL_NONE     = 2'd0;
    localparam logic [1:0] LVL_MEDIUM   = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEVEL_TABLE  = 2'd0;
    localparam logic [1:0] CFG_UNMUTE_DELAY = 2'd1;

    localparam logic [15:0] UNMUTE_DELAY_RST = 16'd12000;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

    // Result item, last member in the lowest bits
    typedef struct packed {
        logic       ack_refused;
        logic       raise_accepted;
        logic       alarm_changed;
        logic       led_high;
        logic       led_medium;
        logic       led_normal;
        logic       muted;
        logic [1:0] active_level;
        logic [3:0] active_cause;
    } t_result;

    // Level of a cause; causes at or above the cause count read as none
    function automatic logic [1:0] level_of(input logic [31:0] tbl, input logic [3:0] c,
                                            input logic [4:0] ncauses);
        if ({1'b0, c} >= ncauses) begin
            return LVL_NONE;
        end
        return tbl[{c, 1'b0} +: 2];
    endfunction

endpackage

`default_nettype wire

// ----- src/plam_core.sv -----
// Alarm state: config registers, pending/active cause, mute flag and timer.
// Depends on plam_pkg. Gives the result of the presented item combinationally.
`default_nettype none

module plam_core #(
    parameter int NUM_CAUSES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_func,
    input  wire logic [3:0]        i_cause,
    output plam_pkg::t_result      o_res
);
    import plam_pkg::*;

    localparam logic [4:0] NCAUSES = 5'(NUM_CAUSES);

    logic [31:0] r_level_table;
    logic [15:0] r_unmute_delay;
    logic [3:0]  r_pending, n_pending;
    logic [3:0]  r_current, n_current;
    logic        r_mute, n_mute;
    logic [15:0] r_elapsed, n_elapsed;

    logic [1:0]  lvl_pend;
    logic [1:0]  lvl_in;
    logic [1:0]  lvl_act;
    logic [15:0] elapsed_inc;
    logic        changed;
    logic        accepted;
    logic        refused;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_table  <= '0;
            r_unmute_delay <= UNMUTE_DELAY_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LEVEL_TABLE) begin
                r_level_table <= i_cfg_data;
            end else if (i_cfg_index == CFG_UNMUTE_DELAY) begin
                r_unmute_delay <= i_cfg_data[15:0];
            end
        end
    end

    // Next state for the presented item
    always_comb begin
        lvl_pend    = level_of(r_level_table, r_pending, NCAUSES);
        lvl_in      = level_of(r_level_table, i_cause, NCAUSES);
        elapsed_inc = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 16'd1;
        n_pending   = r_pending;
        n_current   = r_current;
        n_mute      = r_mute;
        n_elapsed   = r_elapsed;
        changed     = 1'b0;
        accepted    = 1'b0;
        refused     = 1'b0;
        case (t_func'(i_func))
            FUNC_RAISE: begin
                if (lvl_in > lvl_pend) begin
                    n_pending = i_cause;
                    accepted  = 1'b1;
                end
            end
            FUNC_ACK: begin
                if (lvl_pend == LVL_CRITICAL) begin
                    refused = 1'b1;
                end else begin
                    n_pending = 4'd0;
                end
            end
            FUNC_MUTE: begin
                n_mute    = !r_mute;
                n_elapsed = '0;
            end
            FUNC_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_mute && (elapsed_inc > r_unmute_delay)) begin
                    n_mute = 1'b0;
                end
                // pending cause becomes active; critical overrides mute
                if (r_pending != r_current) begin
                    n_current = r_pending;
                    changed   = 1'b1;
                    if (lvl_pend == LVL_CRITICAL) begin
                        n_mute = 1'b0;
                    end
                end
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
    end

    // State update on accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_current <= '0;
            r_mute    <= 1'b0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_current <= n_current;
            r_mute    <= n_mute;
            r_elapsed <= n_elapsed;
        end
    end

    // Result fields, state after the item
    always_comb begin
        lvl_act              = level_of(r_level_table, n_current, NCAUSES);
        o_res.active_cause   = n_current;
        o_res.active_level   = lvl_act;
        o_res.muted          = n_mute;
        o_res.led_normal     = (lvl_act == LVL_NONE);
        o_res.led_medium     = (lvl_act == LVL_MEDIUM);
        o_res.led_high       = lvl_act[1];
        o_res.alarm_changed  = changed;
        o_res.raise_accepted = accepted;
        o_res.ack_refused    = refused;
    end

endmodule

`default_nettype wire

// ----- src/priority_alarm_latch_with_mute.sv -----
// Alarm latch with priority levels and timed mute: top level.
// Result item is registered: it appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the single output register is the only stage,
// and a new item is taken whenever that register is empty or being drained.
// Reset: synchronous active low; clears causes, mute, timer, config to defaults.
// Depends on plam_pkg, plam_core and the assertion macro header.
`default_nettype none
`include "priority_alarm_latch_with_mute_defines.svh"

module priority_alarm_latch_with_mute #(
    parameter int NUM_CAUSES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] cause, [7:4] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [3:0] active_cause, [5:4] active_level,
                                             // [6] muted, [7] led_normal, [8] led_medium,
                                             // [9] led_high, [10] alarm_changed,
                                             // [11] raise_accepted, [12] ack_refused,
                                             // [15:13] zero
);
    import plam_pkg::*;

    logic    r_out_valid;
    t_result r_res;
    t_result res;
    logic    in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    plam_core #(
        .NUM_CAUSES (NUM_CAUSES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_func      (s_axis_tuser),
        .i_cause     (s_axis_tdata[3:0]),
        .o_res       (res)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res};

    // Checks
    `PLAM_ASSERT_NXT(a_item_gives_result, in_accept, r_out_valid,
        "accepted item did not load the output register")
    `PLAM_ASSERT_IMP(a_stall_blocks_input, r_out_valid && !m_axis_tready, !s_axis_tready,
        "input taken while result stalled")
    `PLAM_ASSERT_NXT(a_changed_only_tick,
        in_accept && (s_axis_tuser != FUNC_TICK), !r_res.alarm_changed,
        "alarm change flagged on a non-tick item")
    `PLAM_ASSERT_IMP(a_one_led, r_out_valid,
        $onehot({r_res.led_normal, r_res.led_medium, r_res.led_high}),
        "LED outputs not exactly one on")

endmodule

`default_nettype wire

// ----- dv/priority_alarm_latch_with_mute_test.sv -----
// Self-checking testbench for the alarm latch with priority levels and timed mute.
// Needs plam_pkg and the priority_alarm_latch_with_mute RTL; drives every port
// and checks each result item against its own model of the alarm state.
`default_nettype none

module priority_alarm_latch_with_mute_test;

    import plam_pkg::*;

    localparam int          NUM_CAUSES    = 16;
    localparam int          ERR_REPORTS   = 10;
    localparam int          ITEMS_PER_SET = 140;
    localparam int          SETS_PER_MODE = 4;
    localparam int          MUTE_TICKS    = 24;
    // indexes past the register list, the block must ignore them
    localparam logic [1:0]  CFG_SPARE_A   = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B   = 2'd3;
    // medium on causes 1 and 4, high on 2, critical on 3 and 15
    localparam logic [31:0] DIRECTED_LVLS = 32'hC000_01E4;

    // Expected alarm state and the results still owed by the block
    class alarm_status_board;
        logic [31:0] level_tbl;
        logic [15:0] unmute_delay;
        logic [3:0]  pending_cause;
        logic [3:0]  current_cause;
        logic        mute_flag;
        logic [15:0] mute_elapsed;
        t_result     status_due[$];
        int          mismatches;
        int          events_taken;
        int          results_seen;
        int          raises_taken;
        int          acks_refused;
        int          cause_changes;
        int          auto_unmutes;

        function new();
            level_tbl     = 32'd0;
            unmute_delay  = UNMUTE_DELAY_RST;
            pending_cause = 4'd0;
            current_cause = 4'd0;
            mute_flag     = 1'b0;
            mute_elapsed  = 16'd0;
            mismatches    = 0;
            events_taken  = 0;
            results_seen  = 0;
            raises_taken  = 0;
            acks_refused  = 0;
            cause_changes = 0;
            auto_unmutes  = 0;
        endfunction

        function logic [1:0] cause_level(input logic [3:0] c);
            if (int'(c) >= NUM_CAUSES) begin
                return LVL_NONE;
            end
            return level_tbl[2 * c +: 2];
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [31:0] data);
            if (idx == CFG_LEVEL_TABLE) begin
                level_tbl = data;
            end else if (idx == CFG_UNMUTE_DELAY) begin
                unmute_delay = data[15:0];
            end
        endfunction

        // Advance the model by one input item and queue the status it should produce
        function void log_event(input t_func f, input logic [3:0] c);
            t_result     st;
            logic [1:0]  lvl;
            st = '0;
            events_taken++;
            case (f)
                FUNC_RAISE: begin
                    if (cause_level(c) > cause_level(pending_cause)) begin
                        pending_cause     = c;
                        st.raise_accepted = 1'b1;
                        raises_taken++;
                    end
                end
                FUNC_ACK: begin
                    if (cause_level(pending_cause) == LVL_CRITICAL) begin
                        st.ack_refused = 1'b1;
                        acks_refused++;
                    end else begin
                        pending_cause = 4'd0;
                    end
                end
                FUNC_MUTE: begin
                    mute_flag    = !mute_flag;
                    mute_elapsed = 16'd0;
                end
                default: begin
                    // timer saturates, so a maximum delay never expires
                    if (mute_elapsed != TIMER_MAX) begin
                        mute_elapsed = mute_elapsed + 16'd1;
                    end
                    if (mute_flag && mute_elapsed > unmute_delay) begin
                        mute_flag = 1'b0;
                        auto_unmutes++;
                    end
                    if (pending_cause != current_cause) begin
                        current_cause    = pending_cause;
                        st.alarm_changed = 1'b1;
                        cause_changes++;
                        if (cause_level(current_cause) == LVL_CRITICAL) begin
                            mute_flag = 1'b0;
                        end
                    end
                end
            endcase
            // level is looked up live from the table
            lvl             = cause_level(current_cause);
            st.active_cause = current_cause;
            st.active_level = lvl;
            st.muted        = mute_flag;
            st.led_normal   = (lvl == LVL_NONE);
            st.led_medium   = (lvl == LVL_MEDIUM);
            st.led_high     = (lvl > LVL_MEDIUM);
            status_due.push_back(st);
        endfunction

        // Compare one result item with the oldest queued status
        function void match_status(input logic [15:0] data);
            t_result got;
            t_result want;
            logic    bad;
            got = t_result'(data[12:0]);
            results_seen++;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= ERR_REPORTS) begin
                    $display("unexpected result item %h with nothing outstanding", data);
                end
                return;
            end
            want = status_due.pop_front();
            bad  = (data[15:13] !== 3'd0)
                || (got.active_cause   !== want.active_cause)
                || (got.active_level   !== want.active_level)
                || (got.muted          !== want.muted)
                || (got.led_normal     !== want.led_normal)
                || (got.led_medium     !== want.led_medium)
                || (got.led_high       !== want.led_high)
                || (got.alarm_changed  !== want.alarm_changed)
                || (got.raise_accepted !== want.raise_accepted)
                || (got.ack_refused    !== want.ack_refused);
            if (bad) begin
                mismatches++;
                if (mismatches <= ERR_REPORTS) begin
                    $display("result %0d mismatch", results_seen);
                    $display("    expected: cause=%0d lvl=%0d mute=%b nmh=%b%b%b %b%b%b pad=000",
                             want.active_cause, want.active_level, want.muted,
                             want.led_normal, want.led_medium, want.led_high,
                             want.alarm_changed, want.raise_accepted, want.ack_refused);
                    $display("    actual:   cause=%0d lvl=%0d mute=%b nmh=%b%b%b %b%b%b pad=%b",
                             got.active_cause, got.active_level, got.muted,
                             got.led_normal, got.led_medium, got.led_high,
                             got.alarm_changed, got.raise_accepted, got.ack_refused,
                             data[15:13]);
                end
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_LEVEL_TABLE;
    logic [31:0] i_cfg_data    = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [3:0] cause, [7:4] zero
    logic [1:0]  s_axis_tuser  = FUNC_RAISE;   // [1:0] func
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;   // [3:0] cause, [5:4] level, [6] muted, [9:7] leds,
                                 // [10] changed, [11] accepted, [12] refused

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                settings_used = 0;
    alarm_status_board board = new();

    priority_alarm_latch_with_mute #(
        .NUM_CAUSES(NUM_CAUSES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe handshakes on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.write_reg(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.log_event(t_func'(s_axis_tuser), s_axis_tdata[3:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.match_status(m_axis_tdata);
            end
        end
    end

    // One register write; valid drops afterwards, before the task returns
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // Present one item; valid stays high if the caller follows straight on
    task automatic push_event(input t_func f, input logic [3:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, c};
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait for every owed result, plus the pipeline stage
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.status_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_event();
        int   r;
        t_func f;
        r = $urandom_range(99);
        if (r < 38) begin
            f = FUNC_RAISE;
        end else if (r < 52) begin
            f = FUNC_ACK;
        end else if (r < 60) begin
            f = FUNC_MUTE;
        end else begin
            f = FUNC_TICK;
        end
        push_event(f, 4'($urandom_range(15)));
    endtask

    initial begin
        int          k;
        int          mode;
        logic [31:0] lvls;
        logic [15:0] dly;

        send_idle_pct = 19;
        recv_idle_pct = 45;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: priority ordering, refused acks, mute and unmute paths
        cfg_write(CFG_LEVEL_TABLE, DIRECTED_LVLS);
        cfg_write(CFG_UNMUTE_DELAY, 32'd2);
        push_event(FUNC_RAISE, 4'd0);    // level none never accepted
        push_event(FUNC_RAISE, 4'd1);
        push_event(FUNC_RAISE, 4'd4);    // same level, kept
        push_event(FUNC_RAISE, 4'd2);
        push_event(FUNC_TICK, 4'($urandom_range(15)));
        push_event(FUNC_ACK, 4'($urandom_range(15)));
        push_event(FUNC_TICK, 4'($urandom_range(15)));
        push_event(FUNC_RAISE, 4'd3);
        push_event(FUNC_ACK, 4'd0);      // critical, refused
        push_event(FUNC_MUTE, 4'd15);
        push_event(FUNC_TICK, 4'd15);    // critical becomes active, unmutes
        push_event(FUNC_MUTE, 4'd0);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_TICK, 4'd0);     // delay passed, auto unmute
        push_event(FUNC_RAISE, 4'd15);   // critical over critical, kept
        push_event(FUNC_MUTE, 4'd7);
        push_event(FUNC_MUTE, 4'd8);
        push_event(FUNC_ACK, 4'd15);
        push_event(FUNC_TICK, 4'd15);
        drain_results();
        // spare indexes must not disturb anything
        cfg_write(CFG_SPARE_A, $urandom);
        cfg_write(CFG_SPARE_B, $urandom);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_ACK, 4'd0);
        drain_results();

        // Random items across idling modes and register settings
        for (k = 0; k < 3 * SETS_PER_MODE; k++) begin
            mode = k / SETS_PER_MODE;
            send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 45 : 0;
            recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 19 : 0;
            case (k % 4)
                0:       lvls = $urandom;
                1:       lvls = 32'hFFFF_FFFF;
                2:       lvls = 32'h0000_0000;
                default: lvls = $urandom;
            endcase
            case (k % 3)
                0:       dly = 16'($urandom_range(6));
                1:       dly = ((k / 3) % 2 == 0) ? 16'd0 : TIMER_MAX;
                default: dly = 16'($urandom_range(65535));
            endcase
            cfg_write(CFG_LEVEL_TABLE, lvls);
            cfg_write(CFG_UNMUTE_DELAY, {16'($urandom_range(65535)), dly});
            repeat (ITEMS_PER_SET) random_event();
            drain_results();
        end

        // Long mute under the never-expiring delay, then shorten the delay
        cfg_write(CFG_LEVEL_TABLE, $urandom);
        cfg_write(CFG_UNMUTE_DELAY, {16'd0, TIMER_MAX});
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_TICK, 4'd0);
        drain_results();
        if (!board.mute_flag) begin
            push_event(FUNC_MUTE, 4'd0);
        end
        repeat (MUTE_TICKS) push_event(FUNC_TICK, 4'($urandom_range(15)));
        drain_results();
        cfg_write(CFG_UNMUTE_DELAY, 32'd100);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_MUTE, 4'd0);
        push_event(FUNC_TICK, 4'd0);
        drain_results();

        $display("Ran %0d items under %0d register writes with three idling modes.",
                 board.events_taken, settings_used);
        $display("Saw %0d raises taken, %0d refused acks, %0d cause changes, %0d auto unmutes.",
                 board.raises_taken, board.acks_refused, board.cause_changes,
                 board.auto_unmutes);
        if (board.mismatches == 0 && board.status_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     board.mismatches, board.status_due.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
